// ===== rtl/core/pwoc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwoc_pkg: shared types for the particle wall and obstacle collision core
// Word layout, opcodes and fixed-point saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pwoc_pkg;

   localparam int OBSTACLE_SLOTS_DEF = 8;
   localparam int SLOT_W  = 3;
   localparam int OP_W    = 2;
   localparam int CSR_W   = 3;
   localparam int CSR_DW  = 31;
   localparam int DAMP_W  = 18;

   localparam logic [OP_W-1:0] OP_RESOLVE = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   localparam logic [CSR_W-1:0] CSR_WORLD_WIDTH  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_WORLD_HEIGHT = 3'd1;
   localparam logic [CSR_W-1:0] CSR_PART_SIZE    = 3'd2;
   localparam logic [CSR_W-1:0] CSR_PART_RADIUS  = 3'd3;
   localparam logic [CSR_W-1:0] CSR_DAMPING      = 3'd4;

   // For a rectangle write, px/py/vx/vy carry min_x/min_y/max_x/max_y.
   typedef struct packed {
      logic                     valid;
      logic [OP_W-1:0]          op;
      logic [SLOT_W-1:0]        slot;
      logic signed [31:0]       px;
      logic signed [31:0]       py;
      logic signed [31:0]       vx;
      logic signed [31:0]       vy;
   } item_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat_q16(input logic signed [52:0] p);
      logic signed [36:0] q;
      logic signed [31:0] r;
      q = p[52:16];
      if (q > 37'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (q < -37'sh0_8000_0000) r = 32'sh8000_0000;
      else r = q[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/particle_wall_obstacle_collision_core.sv =====
// ----------------------------------------------------------------------------
// particle_wall_obstacle_collision_core: particle wall and obstacle response
// Clamps a particle into the world box, then resolves it against obstacles.
// ----------------------------------------------------------------------------
// The req channel takes one word per cycle unless the core stalls; tuser holds
// the opcode. A resolve word yields one rsp word with the corrected position
// and velocity. Rectangle write and clear words travel down the same pipeline,
// update the obstacle slots as they pass them (a write its addressed slot, a
// clear every slot) and yield no rsp word, so every particle sees exactly the
// table left by the words accepted before it. There are three wall stages,
// then four stages per slot for clamp, squares, push and damping. When the
// receiver stalls a waiting rsp word, the whole pipeline holds and req_tready
// falls in the same cycle. Reset clears all valid bits and every obstacle
// slot, and loads the default register values. The csr port writes registers
// directly; the user must use it only while no word is in flight, as the core
// does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_wall_obstacle_collision_core import pwoc_pkg::*; #(
   parameter int OBSTACLE_SLOTS = OBSTACLE_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // slot, pos_x, pos_y, vel_x, vel_y, rect_min_x, rect_min_y, rect_max_x,
   // rect_max_y, zero fill
   input  wire logic [263:0]      req_tdata,
   // opcode
   input  wire logic [OP_W-1:0]   req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
   output logic [127:0]           rsp_tdata,
   input  wire logic              csr_we,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   logic [30:0]       width_ff, height_ff, size_ff, radius_ff;
   logic [DAMP_W-1:0] damp_ff;
   logic [61:0]       r2_ff;
   logic signed [18:0] kd;
   logic en;
   item_type in_item, wall_out, last_item;
   item_type chain [OBSTACLE_SLOTS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 31'd524288;
         height_ff <= 31'd294912;
         size_ff   <= 31'd1704;
         radius_ff <= 31'd852;
         damp_ff   <= 18'd58982;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WORLD_WIDTH:  width_ff  <= csr_wdata;
            CSR_WORLD_HEIGHT: height_ff <= csr_wdata;
            CSR_PART_SIZE:    size_ff   <= csr_wdata;
            CSR_PART_RADIUS:  radius_ff <= csr_wdata;
            CSR_DAMPING:      damp_ff   <= csr_wdata[DAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   assign kd = 19'sd65536 - signed'({1'b0, damp_ff});

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      in_item.valid = req_tvalid;
      in_item.op    = req_tuser;
      in_item.slot  = req_tdata[2:0];
      if (req_tuser == OP_WRITE) begin
         in_item.px = req_tdata[162:131];
         in_item.py = req_tdata[194:163];
         in_item.vx = req_tdata[226:195];
         in_item.vy = req_tdata[258:227];
      end else begin
         in_item.px = req_tdata[34:3];
         in_item.py = req_tdata[66:35];
         in_item.vx = req_tdata[98:67];
         in_item.vy = req_tdata[130:99];
      end
   end

   pwoc_wall u_wall (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .half     (size_ff[30:1]),
      .w        (width_ff),
      .h        (height_ff),
      .d        (damp_ff),
      .in_item  (in_item),
      .out_item (wall_out)
   );

   assign chain[0] = wall_out;

   for (genvar k = 0; k < OBSTACLE_SLOTS; k++) begin : g_slot
      pwoc_slot #(.K(k)) u_slot (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .r        (radius_ff),
         .r2       (r2_ff),
         .kd       (kd),
         .in_item  (chain[k]),
         .out_item (chain[k+1])
      );
   end

   assign last_item  = chain[OBSTACLE_SLOTS];
   assign rsp_tvalid = last_item.valid && (last_item.op == OP_RESOLVE);
   assign rsp_tdata  = {last_item.vy, last_item.vx, last_item.py, last_item.px};

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("Response word valid right after reset.");

   a_wall_left: assert property (@(posedge clock) disable iff (reset)
      (wall_out.valid && (wall_out.op == OP_RESOLVE)) |->
      (signed'({wall_out.px[31], wall_out.px}) >= signed'({3'b000, size_ff[30:1]})))
      else $error("Wall stage left a particle beyond the left wall.");

   a_wall_top: assert property (@(posedge clock) disable iff (reset)
      (wall_out.valid && (wall_out.op == OP_RESOLVE)) |->
      (signed'({wall_out.py[31], wall_out.py}) >= signed'({3'b000, size_ff[30:1]})))
      else $error("Wall stage left a particle beyond the top wall.");

endmodule

`default_nettype wire

// ===== rtl/core/pwoc_wall.sv =====
// ----------------------------------------------------------------------------
// pwoc_wall: world box clamp
// Three stages: right/bottom test, left/top test, final damping of velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module pwoc_wall import pwoc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic [29:0]       half,
   input  wire logic [30:0]       w,
   input  wire logic [30:0]       h,
   input  wire logic [DAMP_W-1:0] d,
   input  wire item_type          in_item,
   output item_type               out_item
);

   item_type a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic a_hx_ff, a_hy_ff, b_hx_ff, b_hy_ff;
   logic signed [50:0] a_mx_ff, a_my_ff, b_mx_ff, b_my_ff;
   logic a_hx_in, a_hy_in, b_hx_in, b_hy_in;
   logic signed [50:0] a_mx_in, a_my_in, b_mx_in, b_my_in;
   logic signed [32:0] sum_x, sum_y, half_s;
   logic signed [18:0] d_s;
   logic resolve_in, resolve_a;

   assign half_s = signed'({3'b000, half});
   assign d_s    = signed'({1'b0, d});

   always_comb begin
      a_in       = in_item;
      resolve_in = in_item.valid && (in_item.op == OP_RESOLVE);
      sum_x      = {in_item.px[31], in_item.px} + half_s;
      sum_y      = {in_item.py[31], in_item.py} + half_s;
      a_hx_in    = resolve_in && (sum_x > signed'({2'b00, w}));
      a_hy_in    = resolve_in && (sum_y > signed'({2'b00, h}));
      if (a_hx_in) begin
         a_in.px = signed'({1'b0, w} - {2'b00, half});
      end
      if (a_hy_in) begin
         a_in.py = signed'({1'b0, h} - {2'b00, half});
      end
      a_mx_in = in_item.vx * d_s;
      a_my_in = in_item.vy * d_s;
   end

   always_comb begin
      b_in      = a_ff;
      resolve_a = a_ff.valid && (a_ff.op == OP_RESOLVE);
      if (a_hx_ff) begin
         b_in.vx = sat_q16(-53'(a_mx_ff));
      end
      if (a_hy_ff) begin
         b_in.vy = sat_q16(-53'(a_my_ff));
      end
      b_hx_in = resolve_a && (b_in.px < signed'({2'b00, half}));
      b_hy_in = resolve_a && (b_in.py < signed'({2'b00, half}));
      if (b_hx_in) begin
         b_in.px = signed'({2'b00, half});
      end
      if (b_hy_in) begin
         b_in.py = signed'({2'b00, half});
      end
      b_mx_in = b_in.vx * d_s;
      b_my_in = b_in.vy * d_s;
   end

   always_comb begin
      c_in = b_ff;
      if (b_hx_ff) begin
         c_in.vx = sat_q16(-53'(b_mx_ff));
      end
      if (b_hy_ff) begin
         c_in.vy = sat_q16(-53'(b_my_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
         a_hx_ff    <= 1'b0;
         a_hy_ff    <= 1'b0;
         b_hx_ff    <= 1'b0;
         b_hy_ff    <= 1'b0;
      end else if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         a_hx_ff <= a_hx_in;
         a_hy_ff <= a_hy_in;
         b_hx_ff <= b_hx_in;
         b_hy_ff <= b_hy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mx_ff <= a_mx_in;
         a_my_ff <= a_my_in;
         b_mx_ff <= b_mx_in;
         b_my_ff <= b_my_in;
      end
   end

   assign out_item = c_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pwoc_slot.sv =====
// ----------------------------------------------------------------------------
// pwoc_slot: one obstacle rectangle and its four-stage collision test
// The rectangle is updated as its own write words and clear words pass the first stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pwoc_slot import pwoc_pkg::*; #(
   parameter int K = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic [30:0]       r,
   input  wire logic [61:0]       r2,
   input  wire logic signed [18:0] kd,
   input  wire item_type          in_item,
   output item_type               out_item
);

   logic               vld_ff;
   logic signed [31:0] mnx_ff, mny_ff, mxx_ff, mxy_ff;

   item_type s1_ff, s2_ff, s3_ff, s4_ff, s3_in, s4_in;
   logic s1_near_ff, s1_xp_ff, s1_xn_ff, s1_yp_ff, s1_yn_ff;
   logic s1_near_in;
   logic [30:0] s1_adx_ff, s1_ady_ff;
   logic s2_near_ff, s2_xp_ff, s2_xn_ff, s2_yp_ff, s2_yn_ff;
   logic [61:0] s2_sqx_ff, s2_sqy_ff;
   logic [30:0] s2_penx_ff, s2_peny_ff;
   logic s3_ux_ff, s3_uy_ff, s3_ux_in, s3_uy_in;
   logic signed [50:0] s3_m_ff, s3_m_in;

   logic resolve_in, wr_hit;
   logic signed [31:0] tx, ty, cx, cy;
   logic signed [32:0] dx, dy;
   logic [32:0] adx, ady;
   logic hit, selx;
   logic signed [31:0] vsel;

   assign resolve_in = in_item.valid && (in_item.op == OP_RESOLVE);
   assign wr_hit     = in_item.valid && (in_item.op == OP_WRITE) &&
                       (int'(in_item.slot) == K);

   always_comb begin
      tx  = (in_item.px > mnx_ff) ? in_item.px : mnx_ff;
      cx  = (tx < mxx_ff) ? tx : mxx_ff;
      ty  = (in_item.py > mny_ff) ? in_item.py : mny_ff;
      cy  = (ty < mxy_ff) ? ty : mxy_ff;
      dx  = {in_item.px[31], in_item.px} - {cx[31], cx};
      dy  = {in_item.py[31], in_item.py} - {cy[31], cy};
      adx = dx[32] ? unsigned'(-dx) : unsigned'(dx);
      ady = dy[32] ? unsigned'(-dy) : unsigned'(dy);
      s1_near_in = resolve_in && vld_ff && (adx < {2'b00, r}) && (ady < {2'b00, r});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         if (wr_hit) begin
            vld_ff <= 1'b1;
         end else if (in_item.valid && (in_item.op == OP_CLEAR)) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && wr_hit) begin
         mnx_ff <= in_item.px;
         mny_ff <= in_item.py;
         mxx_ff <= in_item.vx;
         mxy_ff <= in_item.vy;
      end
   end

   always_comb begin
      hit   = s2_near_ff && (({1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff}) < {1'b0, r2});
      selx  = s2_penx_ff < s2_peny_ff;
      s3_in = s2_ff;
      s3_ux_in = hit && selx && (s2_xp_ff || s2_xn_ff);
      s3_uy_in = hit && !selx && (s2_yp_ff || s2_yn_ff);
      if (s3_ux_in) begin
         s3_in.px = s2_xp_ff ?
            sat33({s2_ff.px[31], s2_ff.px} + signed'({2'b00, s2_penx_ff})) :
            sat33({s2_ff.px[31], s2_ff.px} - signed'({2'b00, s2_penx_ff}));
      end
      if (s3_uy_in) begin
         s3_in.py = s2_yp_ff ?
            sat33({s2_ff.py[31], s2_ff.py} + signed'({2'b00, s2_peny_ff})) :
            sat33({s2_ff.py[31], s2_ff.py} - signed'({2'b00, s2_peny_ff}));
      end
      vsel    = selx ? s2_ff.vx : s2_ff.vy;
      s3_m_in = vsel * kd;
   end

   always_comb begin
      s4_in = s3_ff;
      if (s3_ux_ff) begin
         s4_in.vx = sat_q16(53'(s3_m_ff));
      end
      if (s3_uy_ff) begin
         s4_in.vy = sat_q16(53'(s3_m_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s1_near_ff  <= 1'b0;
         s2_near_ff  <= 1'b0;
         s3_ux_ff    <= 1'b0;
         s3_uy_ff    <= 1'b0;
      end else if (en) begin
         s1_ff      <= in_item;
         s1_near_ff <= s1_near_in;
         s2_ff      <= s1_ff;
         s2_near_ff <= s1_near_ff;
         s3_ff      <= s3_in;
         s3_ux_ff   <= s3_ux_in;
         s3_uy_ff   <= s3_uy_in;
         s4_ff      <= s4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_xp_ff   <= !dx[32] && (dx != 33'sd0);
         s1_xn_ff   <= dx[32];
         s1_yp_ff   <= !dy[32] && (dy != 33'sd0);
         s1_yn_ff   <= dy[32];
         s1_adx_ff  <= adx[30:0];
         s1_ady_ff  <= ady[30:0];
         s2_xp_ff   <= s1_xp_ff;
         s2_xn_ff   <= s1_xn_ff;
         s2_yp_ff   <= s1_yp_ff;
         s2_yn_ff   <= s1_yn_ff;
         s2_sqx_ff  <= s1_adx_ff * s1_adx_ff;
         s2_sqy_ff  <= s1_ady_ff * s1_ady_ff;
         s2_penx_ff <= r - s1_adx_ff;
         s2_peny_ff <= r - s1_ady_ff;
         s3_m_ff    <= s3_m_in;
      end
   end

   assign out_item = s4_ff;

endmodule

`default_nettype wire

// ===== test/tb_particle_wall_obstacle_collision_core.sv =====
// ----------------------------------------------------------------------------
// tb_particle_wall_obstacle_collision_core: self-checking collision testbench
// Drives resolve, rectangle write, clear and unused opcode words with random
// idling and one long receiver stall, predicts each result word from a local
// model of the walls and the obstacle table, and checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_particle_wall_obstacle_collision_core import pwoc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  SLOTS       = 8;
   localparam int  DRAIN       = 45;
   localparam int  CYCLE_LIMIT = 600000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] vx;
      logic [31:0] vy;
   } motion_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [263:0]      req_tdata;
   logic [OP_W-1:0]   req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [127:0]      rsp_tdata;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   longint world_w, world_h, part_size, part_radius, damping;
   longint rect_lo_x [SLOTS];
   longint rect_lo_y [SLOTS];
   longint rect_hi_x [SLOTS];
   longint rect_hi_y [SLOTS];
   bit     rect_live [SLOTS];

   motion_type expected_motion[$];
   int      mismatches;
   int      cycles;
   bit      idle_on;
   bit      long_hold;

   particle_wall_obstacle_collision_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic motion_type resolve_particle(input logic signed [31:0] ipx,
         input logic signed [31:0] ipy, input logic signed [31:0] ivx,
         input logic signed [31:0] ivy);
      longint px, py, vx, vy, half, cx, cy, dx, dy, adx, ady, penx, peny, s;
      longint unsigned dist2, rad2;
      motion_type o;
      px = ipx; py = ipy; vx = ivx; vy = ivy;
      half = part_size >>> 1;
      if (px + half > world_w) begin px = world_w - half; vx = sat32((-(vx * damping)) >>> 16); end
      if (py + half > world_h) begin py = world_h - half; vy = sat32((-(vy * damping)) >>> 16); end
      if (px - half < 0) begin px = half; vx = sat32((-(vx * damping)) >>> 16); end
      if (py - half < 0) begin py = half; vy = sat32((-(vy * damping)) >>> 16); end
      for (int i = 0; i < SLOTS; i++) begin
         if (!rect_live[i]) continue;
         cx = (px > rect_lo_x[i]) ? px : rect_lo_x[i];
         cx = (cx < rect_hi_x[i]) ? cx : rect_hi_x[i];
         cy = (py > rect_lo_y[i]) ? py : rect_lo_y[i];
         cy = (cy < rect_hi_y[i]) ? cy : rect_hi_y[i];
         dx = px - cx;
         dy = py - cy;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         if (adx >= part_radius || ady >= part_radius) continue;
         dist2 = adx * adx + ady * ady;
         rad2 = part_radius * part_radius;
         if (dist2 >= rad2) continue;
         penx = part_radius - adx;
         peny = part_radius - ady;
         if (penx < peny) begin
            s = (dx > 0) - (dx < 0);
            if (s != 0) begin
               px = sat32(px + s * penx);
               vx = sat32((vx * (65536 - damping)) >>> 16);
            end
         end else begin
            s = (dy > 0) - (dy < 0);
            if (s != 0) begin
               py = sat32(py + s * peny);
               vy = sat32((vy * (65536 - damping)) >>> 16);
            end
         end
      end
      o.px = px[31:0]; o.py = py[31:0]; o.vx = vx[31:0]; o.vy = vy[31:0];
      return o;
   endfunction

   // Payload order from the low end: pos_x, pos_y, vel_x, vel_y, then the
   // rectangle min_x, min_y, max_x, max_y.
   task automatic apply_word(input logic [OP_W-1:0] op, input logic [2:0] slot,
         input logic [255:0] pl);
      case (op)
         OP_RESOLVE: begin
            expected_motion.insert(expected_motion.size(),
                                   resolve_particle(pl[31:0], pl[63:32],
                                                    pl[95:64], pl[127:96]));
         end
         OP_WRITE: begin
            rect_lo_x[slot] = longint'($signed(pl[159:128]));
            rect_lo_y[slot] = longint'($signed(pl[191:160]));
            rect_hi_x[slot] = longint'($signed(pl[223:192]));
            rect_hi_y[slot] = longint'($signed(pl[255:224]));
            rect_live[slot] = 1'b1;
         end
         OP_CLEAR: begin
            foreach (rect_live[i]) rect_live[i] = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_word(input logic [OP_W-1:0] op, input logic [2:0] slot,
         input logic [255:0] pl);
      bit ready;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, pl, slot};
      do begin
         @(negedge clock);
         ready = req_tready;
         @(posedge clock);
      end while (!ready);
      apply_word(op, slot, pl);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
         input logic [31:0] vx, input logic [31:0] vy);
      send_word(OP_RESOLVE, 3'($urandom_range(0, 7)), {$urandom, $urandom, $urandom,
                $urandom, vy, vx, py, px});
   endtask

   task automatic send_rect(input logic [2:0] slot, input logic [31:0] lx,
         input logic [31:0] ly, input logic [31:0] hx, input logic [31:0] hy);
      send_word(OP_WRITE, slot, {hy, hx, ly, lx, $urandom, $urandom, $urandom, $urandom});
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input longint value);
      req_tvalid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WORLD_WIDTH:  world_w     = value & 64'h7FFF_FFFF;
         CSR_WORLD_HEIGHT: world_h     = value & 64'h7FFF_FFFF;
         CSR_PART_SIZE:    part_size   = value & 64'h7FFF_FFFF;
         CSR_PART_RADIUS:  part_radius = value & 64'h7FFF_FFFF;
         CSR_DAMPING:      damping     = value & 64'h3FFFF;
         default: begin
         end
      endcase
   endtask

   function automatic logic [31:0] pick_near(input longint lo, input longint hi);
      longint span;
      span = hi - lo;
      if (span <= 0) return lo[31:0];
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      return 32'(lo + longint'($urandom_range(0, span[31:0])));
   endfunction

   function automatic logic [31:0] pick_vel();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   // Mostly particles near the walls and near stored rectangles, some new
   // rectangles, clears, unused opcodes and fully random words.
   task automatic random_traffic(input int count);
      longint half, r, cx, cy, sx, sy;
      int k, sel;
      for (int n = 0; n < count; n++) begin
         half = part_size >>> 1;
         r = part_radius;
         sel = int'($urandom_range(0, 99));
         if (sel < 8) begin
            cx = pick_near(0, world_w);
            cy = pick_near(0, world_h);
            sx = longint'($urandom_range(0, 4 * r[29:0] + 65536));
            sy = longint'($urandom_range(0, 4 * r[29:0] + 65536));
            if ($urandom_range(0, 9) == 0) begin
               send_rect(3'($urandom), $urandom, $urandom, $urandom, $urandom);
            end else begin
               send_rect(3'($urandom), 32'(cx - sx), 32'(cy - sy), 32'(cx + sx),
                         32'(cy + sy));
            end
         end else if (sel < 10) begin
            send_word(OP_CLEAR, 3'($urandom), {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
         end else if (sel < 12) begin
            send_word(OP_UNUSED, 3'($urandom), {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
         end else if (sel < 20) begin
            send_particle($urandom, $urandom, $urandom, $urandom);
         end else if (sel < 55) begin
            k = int'($urandom_range(0, SLOTS - 1));
            if (rect_live[k]) begin
               send_particle(pick_near(rect_lo_x[k] - r - 2, rect_hi_x[k] + r + 2),
                             pick_near(rect_lo_y[k] - r - 2, rect_hi_y[k] + r + 2),
                             pick_vel(), pick_vel());
            end else begin
               send_particle(pick_near(-half - 8, world_w + half + 8),
                             pick_near(-half - 8, world_h + half + 8), pick_vel(), pick_vel());
            end
         end else begin
            send_particle(pick_near(-half - 8, world_w + half + 8),
                          pick_near(-half - 8, world_h + half + 8), pick_vel(), pick_vel());
         end
      end
   endtask

   task automatic test_field_extremes();
      send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_particle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_particle(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_particle(32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_word(OP_UNUSED, 3'd7, {8{32'hFFFF_FFFF}});
   endtask

   task automatic test_obstacle_cases();
      // A rectangle from (3,1) to (5,3) meters in slot zero.
      send_rect(3'd0, 32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 32'h0003_0000);
      send_particle(32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(32'h0005_0100, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_1000);
      send_particle(32'h0004_0000, 32'h0000_FF00, 32'h0000_1000, 32'h0002_0000);
      // Equal penetration on both axes at the corner.
      send_particle(32'h0005_0100, 32'h0003_0100, 32'h0001_0000, 32'h0001_0000);
      // Inverted rectangle in the last slot.
      send_rect(3'd7, 32'h0006_0000, 32'h0002_0000, 32'h0005_0000, 32'h0001_0000);
      send_particle(32'h0005_0080, 32'h0001_0080, 32'h0001_0000, 32'hFFFF_0000);
      send_particle(32'h0005_8000, 32'h0001_8000, 32'h0002_0000, 32'h0002_0000);
      send_word(OP_CLEAR, 3'd0, {8{32'h0}});
      send_particle(32'h0005_0100, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_1000);
      send_rect(3'd3, 32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 32'h0003_0000);
      send_particle(32'h0002_FF80, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000);
   endtask

   task automatic test_settings_sweep();
      write_reg(CSR_PART_RADIUS, 64'h0000_8000);
      write_reg(CSR_DAMPING, 64'd0);
      random_traffic(250);
      write_reg(CSR_WORLD_WIDTH, 64'h7FFF_FFFF);
      write_reg(CSR_WORLD_HEIGHT, 64'h7FFF_FFFF);
      write_reg(CSR_PART_SIZE, 64'd0);
      write_reg(CSR_DAMPING, 64'd131072);
      random_traffic(200);
      write_reg(CSR_WORLD_WIDTH, 64'd0);
      write_reg(CSR_WORLD_HEIGHT, 64'd0);
      write_reg(CSR_PART_SIZE, 64'h7FFF_FFFF);
      write_reg(CSR_PART_RADIUS, 64'd0);
      random_traffic(120);
      write_reg(CSR_PART_RADIUS, 64'h7FFF_FFFF);
      write_reg(CSR_DAMPING, 64'h3FFFF);
      random_traffic(120);
      write_reg(CSR_WORLD_WIDTH, 64'd524288);
      write_reg(CSR_WORLD_HEIGHT, 64'd294912);
      write_reg(CSR_PART_SIZE, 64'd1704);
      write_reg(CSR_PART_RADIUS, 64'd852);
      write_reg(CSR_DAMPING, 64'd58982);
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      idle_on = 1'b0;
      random_traffic(80);
      idle_on = 1'b1;
   endtask

   task automatic test_random_default();
      random_traffic(700);
      idle_on = 1'b0;
      random_traffic(300);
   endtask

   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      motion_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_motion.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            e = expected_motion.pop_front();
            if (rsp_tdata[31:0] !== e.px || rsp_tdata[63:32] !== e.py ||
                rsp_tdata[95:64] !== e.vx || rsp_tdata[127:96] !== e.vy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch pos %h %h vel %h %h, expected pos %h %h vel %h %h",
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                           rsp_tdata[127:96], e.px, e.py, e.vx, e.vy);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_RESOLVE;
      csr_we     = 1'b0;
      csr_index  = CSR_WORLD_WIDTH;
      csr_wdata  = '0;
      reset      = 1'b1;
      mismatches = 0;
      cycles     = 0;
      idle_on    = 1'b1;
      long_hold  = 1'b0;
      world_w = 524288; world_h = 294912; part_size = 1704;
      part_radius = 852; damping = 58982;
      foreach (rect_live[i]) rect_live[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_obstacle_cases();
      test_settings_sweep();
      test_backpressure();
      test_random_default();
      req_tvalid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && expected_motion.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/pwoc_pkg.sv
rtl/core/pwoc_wall.sv
rtl/core/pwoc_slot.sv
rtl/core/particle_wall_obstacle_collision_core.sv
test/tb_particle_wall_obstacle_collision_core.sv
